[hdl/amx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax stream reduce package
// Shared widths, codes, the queue entry type and the float ordering helpers.
// ----------------------------------------------------------------------------
package amx_pkg;

    localparam int WORD_W       = 32;
    localparam int IDX_W        = 31;
    localparam int GIDX_W       = 32;
    localparam int MAX_ELEMENTS = 32767;
    localparam int POS_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
    localparam int APB_AW       = 3;

    localparam logic FMT_INT32    = 1'b0;
    localparam logic FMT_BF16     = 1'b1;
    localparam logic FUNC_ELEMENT = 1'b0;
    localparam logic FUNC_RECORD  = 1'b1;
    localparam logic REG_VALUE_FORMAT = 1'b0;
    localparam logic REG_SLICE_BASE   = 1'b1;

    localparam logic [WORD_W-1:0] LOWEST_INT32 = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWEST_BF16  = 32'hFF7F_0000;

    typedef struct packed {
        logic              value_format;
        logic [IDX_W-1:0]  slice_base;
    } amx_cfg_t;

    typedef struct packed {
        logic              func;
        logic              last;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] key;
        logic              nan;
        logic [IDX_W-1:0]  rec_index;
    } amx_entry_t;

    function automatic logic is_nan32(input logic [WORD_W-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Maps a word to an unsigned key whose order matches the format's order.
    function automatic logic [WORD_W-1:0] order_key(input logic fmt,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] z;
        z = (b[30:0] == 31'd0) ? '0 : b;
        if (fmt == FMT_INT32)
            return b ^ LOWEST_INT32;
        return z[31] ? ~z : (z | LOWEST_INT32);
    endfunction

    function automatic logic [WORD_W-1:0] lowest_word(input logic fmt);
        return (fmt == FMT_BF16) ? LOWEST_BF16 : LOWEST_INT32;
    endfunction

endpackage
`default_nettype wire

[hdl/amx_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax stream channels
// Valid/ready channels for input items and for result records.
// ----------------------------------------------------------------------------
interface amx_item_if import amx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]  rec_index;
    logic              last;

    modport source(output valid, func, value, rec_index, last, input ready);
    modport sink(input valid, func, value, rec_index, last, output ready);
endinterface

interface amx_result_if import amx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [WORD_W-1:0] best_value;
    logic [IDX_W-1:0]  win_index;
    logic              overflow;

    modport source(output valid, best_value, win_index, overflow, input ready);
    modport sink(input valid, best_value, win_index, overflow, output ready);
endinterface
`default_nettype wire

[hdl/argmax_stream_reduce.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax stream reduce
// Streaming first-occurrence argmax over int32 or bfloat16 runs, with merge.
//
// Input beats arrive on the item channel: elements carry one sample, records
// carry a partial result (value and global index) to merge. The beat with
// last set closes the run, and one record leaves on the result channel with
// the winning value, its global index and an overflow flag.
// The APB port holds value_format (offset 0) and the slice base index
// (offset 4). Writing value_format clears the running result.
// A beat is accepted into a four-entry queue by the front end and applied by
// the back end once it is at the head of the queue; the result is registered
// and goes valid as the last beat is applied. The back end sustains one beat per
// cycle unless the result receiver stalls, set by its single compare-and-select.
// If the result receiver stalls, the back end holds and the queue fills;
// the item channel drops ready only when the queue is full.
// Reset clears the queue, the running result and both registers.
// ----------------------------------------------------------------------------
module argmax_stream_reduce import amx_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    amx_item_if.sink          item,
    amx_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic             value_format_reg;
    logic [IDX_W-1:0] slice_base_reg;
    logic             cfg_write;
    logic             clear_run;
    amx_cfg_t         cfg;
    logic             push;
    amx_entry_t       push_data;
    logic             full;
    logic             pop;
    logic             head_valid;
    amx_entry_t       head_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign clear_run = cfg_write && (paddr[2] == REG_VALUE_FORMAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_format_reg <= FMT_INT32;
            slice_base_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_VALUE_FORMAT: value_format_reg <= pwdata[0];
                REG_SLICE_BASE:   slice_base_reg   <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_VALUE_FORMAT: prdata = {31'd0, value_format_reg};
            REG_SLICE_BASE:   prdata = {1'b0, slice_base_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.value_format = value_format_reg;
    assign cfg.slice_base   = slice_base_reg;

    amx_front u_front (
        .item      (item),
        .cfg       (cfg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    amx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .full       (full)
    );

    amx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .clear_run    (clear_run),
        .clear_format (pwdata[0]),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result       (result)
    );

endmodule
`default_nettype wire

[hdl/amx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax front end
// Accepts input beats, widens samples and computes their ordering keys.
// ----------------------------------------------------------------------------
module amx_front import amx_pkg::*; (
    amx_item_if.sink   item,
    input  amx_cfg_t   cfg,
    input  logic       full,
    output logic       push,
    output amx_entry_t push_data
);

    logic [WORD_W-1:0] cand;

    always_comb
    begin
        if (item.func == FUNC_RECORD)
            cand = item.value;
        else if (cfg.value_format == FMT_BF16)
            cand = {item.value[15:0], 16'h0000};
        else
            cand = item.value;
    end

    assign item.ready = !full;
    assign push       = item.valid && !full;

    always_comb
    begin
        push_data.func      = item.func;
        push_data.last      = item.last;
        push_data.word      = cand;
        push_data.key       = order_key(cfg.value_format, cand);
        push_data.nan       = (cfg.value_format == FMT_BF16) && is_nan32(cand);
        push_data.rec_index = item.rec_index;
    end

endmodule
`default_nettype wire

[hdl/amx_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax decoupling queue
// Small register queue between the front end and the reduction back end.
// ----------------------------------------------------------------------------
module amx_queue import amx_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  amx_entry_t push_data,
    input  logic       pop,
    output logic       head_valid,
    output amx_entry_t head_data,
    output logic       full
);

    amx_entry_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 do_pop;

    assign full       = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + FIFO_CW'(1);
        else if (!push && do_pop)
            count_next = count_reg - FIFO_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && !head_valid))
        else $error("queue full and empty at once");

endmodule
`default_nettype wire

[hdl/amx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Argmax back end
// Holds the running best, applies element and record beats, emits records.
// ----------------------------------------------------------------------------
module amx_back import amx_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  amx_cfg_t     cfg,
    input  logic         clear_run,
    input  logic         clear_format,
    input  logic         head_valid,
    input  amx_entry_t   head_data,
    output logic         pop,
    amx_result_if.source result
);

    logic [WORD_W-1:0] best_word_reg;
    logic [WORD_W-1:0] best_key_reg;
    logic              best_nan_reg;
    logic [GIDX_W-1:0] best_idx_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              rec_seen_reg;
    logic              ovf_reg;

    logic [WORD_W-1:0] best_word_next;
    logic [WORD_W-1:0] best_key_next;
    logic              best_nan_next;
    logic [GIDX_W-1:0] best_idx_next;
    logic [POS_W-1:0]  pos_next;
    logic              rec_seen_next;
    logic              ovf_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_ovf_reg;

    logic              stall;
    logic              fresh;
    logic              gt;
    logic              eq;
    logic              take;
    logic [GIDX_W-1:0] elem_idx;
    logic              run_format;
    logic [WORD_W-1:0] low_word;

    assign stall    = out_valid_reg && !result.ready;
    assign pop      = head_valid && !stall;
    assign fresh    = (pos_reg == '0) && !rec_seen_reg;
    assign gt       = !head_data.nan && !best_nan_reg && (head_data.key > best_key_reg);
    assign eq       = !head_data.nan && !best_nan_reg && (head_data.key == best_key_reg);
    assign elem_idx = {1'b0, cfg.slice_base} + GIDX_W'(pos_reg);
    assign take     = fresh || gt ||
                      (eq && ($signed({1'b0, head_data.rec_index}) < $signed(best_idx_reg)));
    assign run_format = clear_run ? clear_format : cfg.value_format;
    assign low_word   = lowest_word(run_format);

    always_comb
    begin
        best_word_next = best_word_reg;
        best_key_next  = best_key_reg;
        best_nan_next  = best_nan_reg;
        best_idx_next  = best_idx_reg;
        pos_next       = pos_reg;
        rec_seen_next  = rec_seen_reg;
        ovf_next       = ovf_reg;
        if (head_data.func == FUNC_ELEMENT)
        begin
            if (pos_reg == POS_W'(MAX_ELEMENTS))
                ovf_next = 1'b1;
            else
            begin
                if (fresh)
                    best_idx_next = {1'b0, cfg.slice_base};
                if (gt)
                begin
                    best_word_next = head_data.word;
                    best_key_next  = head_data.key;
                    best_nan_next  = head_data.nan;
                    best_idx_next  = elem_idx;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else
        begin
            if (take)
            begin
                best_word_next = head_data.word;
                best_key_next  = head_data.key;
                best_nan_next  = head_data.nan;
                best_idx_next  = {1'b0, head_data.rec_index};
            end
            rec_seen_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_word_reg <= LOWEST_INT32;
            best_key_reg  <= order_key(FMT_INT32, LOWEST_INT32);
            best_nan_reg  <= 1'b0;
            best_idx_reg  <= '0;
            pos_reg       <= '0;
            rec_seen_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (result.ready)
                out_valid_reg <= 1'b0;
            if (clear_run || (pop && head_data.last))
            begin
                best_word_reg <= low_word;
                best_key_reg  <= order_key(run_format, low_word);
                best_nan_reg  <= 1'b0;
                best_idx_reg  <= '0;
                pos_reg       <= '0;
                rec_seen_reg  <= 1'b0;
                ovf_reg       <= 1'b0;
            end
            else if (pop)
            begin
                best_word_reg <= best_word_next;
                best_key_reg  <= best_key_next;
                best_nan_reg  <= best_nan_next;
                best_idx_reg  <= best_idx_next;
                pos_reg       <= pos_next;
                rec_seen_reg  <= rec_seen_next;
                ovf_reg       <= ovf_next;
            end
            if (pop && head_data.last)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_data.last)
        begin
            out_value_reg <= best_word_next;
            out_index_reg <= best_idx_next[IDX_W-1:0];
            out_ovf_reg   <= ovf_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.best_value = out_value_reg;
    assign result.win_index  = out_index_reg;
    assign result.overflow   = out_ovf_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_ELEMENTS))
        else $error("position count beyond bound");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (pos_reg == POS_W'(MAX_ELEMENTS)))
        else $error("overflow flag set below the bound");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_data.last) |=> (pos_reg == '0) && !rec_seen_reg && !ovf_reg)
        else $error("run state not cleared after a result");

    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !pop)
        else $error("back end advanced while the result was stalled");

endmodule
`default_nettype wire

[dv/argmax_stream_reduce_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Argmax stream reduce testbench
// Drives runs of elements and partial records through the item channel and
// programs both registers over APB. A scoreboard follows the same argmax and
// merge rules for int32 and bfloat16 samples, and checks every result beat
// against the oldest expected record. Directed runs cover extremes, NaN,
// signed zeros, index wrap and a mid-run format change; random runs follow
// with random gaps on the item channel and stalls on the result channel.
// ----------------------------------------------------------------------------
module argmax_stream_reduce_test;
    import amx_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 1800;

    localparam logic [APB_AW-1:0] FORMAT_ADDR = APB_AW'(4 * REG_VALUE_FORMAT);
    localparam logic [APB_AW-1:0] OFFSET_ADDR = APB_AW'(4 * REG_SLICE_BASE);

    typedef enum int {RUN_ELEMENTS, RUN_RECORDS, RUN_MIXED} run_kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              overflow;
    } argmax_record_t;

    class argmax_scoreboard;
        logic              fmt;
        logic [IDX_W-1:0]  offset;
        logic [WORD_W-1:0] best_word;
        logic [GIDX_W-1:0] best_gidx;
        int unsigned       pos_count;
        logic              rec_seen;
        logic              ovf;
        argmax_record_t    pending_records[$];
        int                errors;

        function new();
            fmt = FMT_INT32;
            offset = '0;
            errors = 0;
            clear_run();
        endfunction

        function void clear_run();
            best_word = (fmt == FMT_BF16) ? 32'hFF7F_0000 : 32'h8000_0000;
            best_gidx = '0;
            pos_count = 0;
            rec_seen = 1'b0;
            ovf = 1'b0;
        endfunction

        function void set_format(logic f);
            fmt = f;
            clear_run();
        endfunction

        function void set_offset(logic [IDX_W-1:0] o);
            offset = o;
        endfunction

        function logic is_nan(logic [WORD_W-1:0] w);
            return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
        endfunction

        // Both zeros share one rank; negatives are inverted so that the
        // unsigned order of ranks follows the float order.
        function logic [WORD_W-1:0] float_rank(logic [WORD_W-1:0] w);
            if (w[30:0] == 31'd0)
                return 32'h8000_0000;
            return w[31] ? ~w : {1'b1, w[30:0]};
        endfunction

        function logic beats(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            if (fmt == FMT_BF16)
                return !is_nan(a) && !is_nan(b) && (float_rank(a) > float_rank(b));
            return $signed(a) > $signed(b);
        endfunction

        function logic ties(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
            if (fmt == FMT_BF16)
                return !is_nan(a) && !is_nan(b) && (float_rank(a) == float_rank(b));
            return a == b;
        endfunction

        function void absorb_item(logic func, logic [WORD_W-1:0] value,
                                  logic [IDX_W-1:0] rec_index, logic last);
            logic              fresh;
            logic              take;
            logic [WORD_W-1:0] cand;
            argmax_record_t    rec;
            fresh = (pos_count == 0) && !rec_seen;
            if (func == FUNC_ELEMENT)
            begin
                if (pos_count >= MAX_ELEMENTS)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    cand = (fmt == FMT_BF16) ? {value[15:0], 16'h0000} : value;
                    if (fresh)
                        best_gidx = {1'b0, offset};
                    if (beats(cand, best_word))
                    begin
                        best_word = cand;
                        best_gidx = {1'b0, offset} + GIDX_W'(pos_count);
                    end
                    pos_count++;
                end
            end
            else
            begin
                take = fresh || beats(value, best_word) ||
                       (ties(value, best_word) &&
                        ($signed({1'b0, rec_index}) < $signed(best_gidx)));
                if (take)
                begin
                    best_word = value;
                    best_gidx = {1'b0, rec_index};
                end
                rec_seen = 1'b1;
            end
            if (last)
            begin
                rec.value = best_word;
                rec.index = best_gidx[IDX_W-1:0];
                rec.overflow = ovf;
                pending_records.push_back(rec);
                clear_run();
            end
        endfunction

        function void check_record(logic [WORD_W-1:0] value, logic [IDX_W-1:0] index,
                                   logic overflow);
            argmax_record_t want;
            if (pending_records.size() == 0)
            begin
                $display("%0t: unexpected result beat value %h index %h overflow %b",
                         $time, value, index, overflow);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            if (value !== want.value)
            begin
                $display("%0t: best_value expected %h, got %h", $time, want.value, value);
                errors++;
            end
            if (index !== want.index)
            begin
                $display("%0t: win_index expected %h, got %h", $time, want.index, index);
                errors++;
            end
            if (overflow !== want.overflow)
            begin
                $display("%0t: overflow expected %b, got %b", $time, want.overflow, overflow);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    amx_item_if   item_ch();
    amx_result_if result_ch();

    argmax_scoreboard sb;
    int  quiet_cycles = 0;
    int  items_sent;
    int  stall_left;
    bit  tx_gaps;
    bit  rx_stalls;

    argmax_stream_reduce dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (rx_stalls && $urandom_range(0, 4) == 0)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                sb.absorb_item(item_ch.func, item_ch.value, item_ch.rec_index, item_ch.last);
            if (result_ch.valid && result_ch.ready)
                sb.check_record(result_ch.best_value, result_ch.win_index,
                                result_ch.overflow);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (psel && penable && pwrite && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] bf16_pattern();
        case ($urandom_range(0, 11))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7F80;
            3: return 16'hFF80;
            4: return 16'h7FC0;
            5: return 16'hFF81;
            6: return 16'h7F7F;
            7: return 16'hFF7F;
            8, 9: return {1'($urandom_range(0, 1)), 15'h3F80 + 15'($urandom_range(0, 3))};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] int_sample();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_sample(logic fmt);
        if (fmt == FMT_BF16)
            return {16'($urandom), bf16_pattern()};
        return int_sample();
    endfunction

    function automatic logic [WORD_W-1:0] pick_record_word(logic fmt);
        if (fmt == FMT_BF16)
            return {bf16_pattern(), ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0000};
        return int_sample();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2, 3: return 31'($urandom_range(0, 15));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return 31'h7FFF_FFFF;
            2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 20));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic func, input logic [WORD_W-1:0] value,
                             input logic [IDX_W-1:0] rec_index, input logic last);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.func      <= func;
        item_ch.value     <= value;
        item_ch.rec_index <= rec_index;
        item_ch.last      <= last;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_format(input logic f);
        wait_idle();
        apb_write(FORMAT_ADDR, {31'd0, f});
        sb.set_format(f);
    endtask

    task automatic write_offset(input logic [IDX_W-1:0] o);
        wait_idle();
        apb_write(OFFSET_ADDR, {1'b0, o});
        sb.set_offset(o);
    endtask

    task automatic send_run(input run_kind_t kind, input int len);
        logic func;
        for (int i = 0; i < len; i++)
        begin
            if (kind == RUN_ELEMENTS)
                func = FUNC_ELEMENT;
            else if (kind == RUN_RECORDS)
                func = FUNC_RECORD;
            else
                func = 1'($urandom_range(0, 1));
            send_item(func,
                      (func == FUNC_RECORD) ? pick_record_word(sb.fmt) : pick_sample(sb.fmt),
                      pick_index(), i == len - 1);
        end
    endtask

    initial
    begin
        int        pick;
        int        len;
        int        phase;
        run_kind_t kind;

        sb = new();
        items_sent = 0;
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.func      <= FUNC_ELEMENT;
        item_ch.value     <= '0;
        item_ch.rec_index <= '0;
        item_ch.last      <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A lone lowest value still reports the slice offset.
        send_item(FUNC_ELEMENT, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1);
        send_item(FUNC_ELEMENT, 32'd5, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h7FFF_FFFF, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h7FFF_FFFF, '0, 1'b1);
        send_item(FUNC_RECORD, 32'd3, 31'd9, 1'b0);
        send_item(FUNC_RECORD, 32'd3, 31'd4, 1'b0);
        send_item(FUNC_RECORD, 32'd2, 31'd1, 1'b1);

        // The second element's global index wraps past bit 30 and becomes
        // negative, so the tying record with index zero does not win.
        write_offset(31'h7FFF_FFFF);
        send_item(FUNC_ELEMENT, 32'd7, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'd9, '0, 1'b0);
        send_item(FUNC_RECORD, 32'd9, '0, 1'b1);

        // A format change drops the open run.
        send_item(FUNC_ELEMENT, 32'd100, '0, 1'b0);
        write_format(FMT_BF16);
        write_offset(31'd40);
        send_item(FUNC_ELEMENT, 32'h0000_7FC0, '0, 1'b1);
        send_item(FUNC_ELEMENT, 32'hABCD_0000, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h1234_8000, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h0000_7F80, '0, 1'b1);
        send_item(FUNC_RECORD, 32'h7FC0_0000, 31'd5, 1'b0);
        send_item(FUNC_ELEMENT, 32'h0000_7F80, '0, 1'b1);
        send_item(FUNC_RECORD, 32'h0000_0000, 31'd8, 1'b0);
        send_item(FUNC_RECORD, 32'h8000_0000, 31'd3, 1'b1);
        send_item(FUNC_ELEMENT, 32'h0000_FF80, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h0000_FF7F, '0, 1'b0);
        send_item(FUNC_ELEMENT, 32'h0000_FF80, '0, 1'b1);

        write_format(FMT_INT32);
        write_offset(31'd0);
        rx_stalls = 1'b1;

        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (phase % 10 == 0)
            begin
                write_format(1'($urandom_range(0, 1)));
                write_offset(pick_offset());
                tx_gaps = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 9);
            kind = (pick < 5) ? RUN_ELEMENTS : (pick < 7) ? RUN_RECORDS : RUN_MIXED;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            send_run(kind, len);
            if ($urandom_range(0, 30) == 0)
                wait_idle();
            phase++;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
